FILE: rtl/core/pfc_pkg.sv
// Shared types, constants and rounding helpers for the pixel format converter.
package pfc_pkg;

  localparam int PFC_MAX_CH   = 4;
  localparam int PFC_SLOTS    = 4;
  localparam int PFC_CH_W     = 32;

  // Channel kind codes.
  localparam logic [1:0] KIND_F32 = 2'd0;
  localparam logic [1:0] KIND_U32 = 2'd1;
  localparam logic [1:0] KIND_U8  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SRC_KIND = 2'd0;
  localparam logic [1:0] REG_DST_KIND = 2'd1;
  localparam logic [1:0] REG_SRC_CH   = 2'd2;
  localparam logic [1:0] REG_DST_CH   = 2'd3;

  // Scale factors as 24-bit significands.
  localparam logic [23:0] K_ONE   = 24'h000001;
  localparam logic [23:0] K_255   = 24'h0000FF;
  // Significand of the single-precision value of 1/255 (and of 2^32/255).
  localparam logic [23:0] K_RECIP = 24'h808081;

  typedef enum logic [2:0] {
    MODE_ZERO,
    MODE_PASS,
    MODE_TRUNC8,
    MODE_TRUNC32,
    MODE_FLOAT
  } mode_t;

  typedef struct packed {
    logic [1:0] src_kind;
    logic [1:0] dst_kind;
    logic       on;
  } lane_cfg_t;

  // Value is m * 2^e, m holding 24 significant bits.
  typedef struct packed {
    logic [23:0]       m;
    logic signed [5:0] e;
  } nr_t;

  // Round a 32-bit integer to 24 significant bits, nearest even.
  function automatic nr_t norm_round(input logic [31:0] x);
    nr_t         r;
    logic [4:0]  p;
    logic [4:0]  sh;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    r.m = 24'd0;
    r.e = 6'sd0;
    p   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    if (p <= 5'd23) begin
      mant = x << (5'd23 - p);
      r.m  = mant[23:0];
      r.e  = $signed({1'b0, p}) - 6'sd23;
    end else begin
      sh   = p - 5'd23;
      mant = x >> sh;
      rem  = x & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 32'd1;
      if (mant[24]) begin
        r.m = 24'h800000;
        r.e = $signed({1'b0, sh}) + 6'sd1;
      end else begin
        r.m = mant[23:0];
        r.e = $signed({1'b0, sh});
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pixel_format_converter_unit.sv
// Top level of the pixel format converter: configuration, lanes and output merge.
//
//  channel | direction | tdata                   | tuser
//  in_     | slave     | in_ch0..in_ch3 (32 each) | -
//  out_    | master    | out_ch0..out_ch3         | bad_channels
//  cfg_    | write     | cfg_wdata, 3 bits        | -
//
// One pixel per cycle while the output is not held; a taken request reaches the
// output through the decode, multiply, and round-and-pack registers of each lane.
// Reset clears the configuration to fp32/fp32, four channels, and empties
// the pipeline. When the output is held, the whole pipeline holds and
// in_tready falls; a waiting result does not block a new request otherwise.
module pixel_format_converter_unit
  import pfc_pkg::*;
#(
  parameter int MAX_CHANNELS = PFC_MAX_CH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // in_ch0, in_ch1, in_ch2, in_ch3
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_ch0, out_ch1, out_ch2, out_ch3
  output logic         out_tuser,  // bad_channels
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [2:0]   cfg_wdata
);

  localparam logic [2:0] MAX_CNT = 3'(MAX_CHANNELS);

  logic [1:0] src_kind_r;
  logic [1:0] dst_kind_r;
  logic [2:0] src_ch_r;
  logic [2:0] dst_ch_r;
  logic [2:0] v_r;
  logic [2:0] bad_r;
  logic       en;
  logic [2:0] sc;
  logic [2:0] dc;
  logic [31:0] lane_res [PFC_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_kind_r <= KIND_F32;
      dst_kind_r <= KIND_F32;
      src_ch_r   <= 3'd4;
      dst_ch_r   <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SRC_KIND: src_kind_r <= cfg_wdata[1:0];
        REG_DST_KIND: dst_kind_r <= cfg_wdata[1:0];
        REG_SRC_CH:   src_ch_r   <= cfg_wdata;
        REG_DST_CH:   dst_ch_r   <= cfg_wdata;
        default:      src_ch_r   <= src_ch_r;
      endcase
    end
  end

  assign sc = (src_ch_r > MAX_CNT) ? MAX_CNT : src_ch_r;
  assign dc = (dst_ch_r > MAX_CNT) ? MAX_CNT : dst_ch_r;

  assign en        = !v_r[2] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'd0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad_r <= {bad_r[1:0], dc > sc};
    end
  end

  for (genvar i = 0; i < PFC_SLOTS; i++) begin : g_slot
    if (i < MAX_CHANNELS) begin : g_lane
      lane_cfg_t lcfg;
      assign lcfg.src_kind = src_kind_r;
      assign lcfg.dst_kind = dst_kind_r;
      assign lcfg.on       = (3'(i) < dc);
      pfc_lane u_lane (
        .clk (clk),
        .en  (en),
        .cfg (lcfg),
        .raw (in_tdata[i*PFC_CH_W +: PFC_CH_W]),
        .res (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = 32'd0;
    end
    assign out_tdata[i*PFC_CH_W +: PFC_CH_W] = lane_res[i];
  end

  assign out_tvalid = v_r[2];
  assign out_tuser  = bad_r[2];

  // A taken request is in the first stage on the next cycle.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted request did not enter the pipeline");

  // A single destination channel leaves the other slots at zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dst_ch_r == 3'd1 |-> out_tdata[127:32] == 96'd0)
    else $error("unproduced channel is not zero");

  // The error flag can only be raised when some channel is produced.
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> dst_ch_r != 3'd0 && dc > sc)
    else $error("bad_channels without excess channels");

endmodule

FILE: rtl/core/pfc_lane.sv
// One channel conversion lane: decode, scale multiply, round and pack.
module pfc_lane
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  lane_cfg_t   cfg,
  input  logic [31:0] raw,
  output logic [31:0] res
);

  // Stage one: operand as significand and exponent.
  mode_t              mode1_r, mode1_nxt;
  logic [23:0]        m1_r, m1_nxt;
  logic [23:0]        k1_r, k1_nxt;
  logic signed [9:0]  e1_r, e1_nxt;
  logic [31:0]        raw1_r, raw1_nxt;
  // Stage two: product.
  mode_t              mode2_r;
  logic [31:0]        q2_r;
  logic signed [9:0]  e2_r;
  logic [31:0]        raw2_r;
  // Stage three: result.
  logic [31:0]        res_r, res_nxt;

  nr_t         nr_in;
  nr_t         nr_q;
  logic [7:0]  fexp_in;
  logic        f_nan;
  logic [47:0] prod;
  logic [23:0] r3;
  logic signed [9:0] ex3;
  logic signed [9:0] nex3;
  logic signed [9:0] fexp3;
  logic [32:0] tv;
  logic [32:0] tmax;

  assign nr_in   = norm_round(raw);
  assign fexp_in = raw[30:23];
  assign f_nan   = (fexp_in == 8'hFF) && (raw[22:0] != 23'd0);

  always_comb begin
    mode1_nxt = MODE_ZERO;
    m1_nxt    = 24'd0;
    k1_nxt    = K_ONE;
    e1_nxt    = 10'sd0;
    raw1_nxt  = raw;
    if (cfg.on) begin
      unique case (cfg.src_kind)
        KIND_F32: begin
          // Clamp to [0,1]; negatives, NaNs and subnormals end up as zero.
          if (raw[31] || f_nan || fexp_in == 8'd0) begin
            m1_nxt = 24'd0;
          end else if (fexp_in >= 8'd127) begin
            m1_nxt = 24'h800000;
            e1_nxt = -10'sd23;
          end else begin
            m1_nxt = {1'b1, raw[22:0]};
            e1_nxt = $signed({2'b00, fexp_in}) - 10'sd150;
          end
          unique case (cfg.dst_kind)
            KIND_F32: mode1_nxt = MODE_PASS;
            KIND_U32: begin
              mode1_nxt = MODE_TRUNC32;
              e1_nxt    = e1_nxt + 10'sd32;
            end
            KIND_U8: begin
              mode1_nxt = MODE_TRUNC8;
              k1_nxt    = K_255;
            end
            default: mode1_nxt = MODE_ZERO;
          endcase
        end
        KIND_U32: begin
          m1_nxt = (raw == 32'd0) ? 24'd0 : nr_in.m;
          e1_nxt = 10'(nr_in.e) - 10'sd32;
          unique case (cfg.dst_kind)
            KIND_F32: mode1_nxt = MODE_FLOAT;
            KIND_U32: mode1_nxt = MODE_PASS;
            KIND_U8: begin
              mode1_nxt = MODE_TRUNC8;
              k1_nxt    = K_255;
            end
            default: mode1_nxt = MODE_ZERO;
          endcase
        end
        KIND_U8: begin
          m1_nxt   = {16'd0, raw[7:0]};
          k1_nxt   = K_RECIP;
          raw1_nxt = {24'd0, raw[7:0]};
          unique case (cfg.dst_kind)
            KIND_F32: begin
              mode1_nxt = MODE_FLOAT;
              e1_nxt    = -10'sd31;
            end
            KIND_U32: begin
              mode1_nxt = MODE_TRUNC32;
              e1_nxt    = 10'sd1;
            end
            KIND_U8:  mode1_nxt = MODE_PASS;
            default:  mode1_nxt = MODE_ZERO;
          endcase
        end
        default: mode1_nxt = MODE_ZERO;
      endcase
    end
  end

  assign prod = m1_r * k1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= mode1_nxt;
      m1_r    <= m1_nxt;
      k1_r    <= k1_nxt;
      e1_r    <= e1_nxt;
      raw1_r  <= raw1_nxt;
      mode2_r <= mode1_r;
      // Every product used here stays below 2^32.
      q2_r    <= prod[31:0];
      e2_r    <= e1_r;
      raw2_r  <= raw1_r;
      res_r   <= res_nxt;
    end
  end

  assign nr_q  = norm_round(q2_r);
  assign r3    = (q2_r == 32'd0) ? 24'd0 : nr_q.m;
  assign ex3   = e2_r + 10'(nr_q.e);
  assign nex3  = -ex3;
  assign fexp3 = ex3 + 10'sd150;
  assign tmax  = (mode2_r == MODE_TRUNC8) ? 33'h0_0000_00FF : 33'h0_FFFF_FFFF;

  always_comb begin
    if (r3 == 24'd0) begin
      tv = 33'd0;
    end else if (!ex3[9]) begin
      tv = (ex3 > 10'sd8) ? tmax : ({9'd0, r3} << ex3[3:0]);
    end else begin
      tv = (nex3 > 10'sd24) ? 33'd0 : ({9'd0, r3} >> nex3[4:0]);
    end
  end

  always_comb begin
    unique case (mode2_r)
      MODE_PASS:    res_nxt = raw2_r;
      MODE_TRUNC8,
      MODE_TRUNC32: res_nxt = (tv > tmax) ? tmax[31:0] : tv[31:0];
      MODE_FLOAT:   res_nxt = (r3 == 24'd0) ? 32'd0 : {1'b0, fexp3[7:0], r3[22:0]};
      default:      res_nxt = 32'd0;
    endcase
  end

  assign res = res_r;

endmodule

FILE: bench/tb_pixel_format_converter_unit.sv
// Self-checking testbench for the pixel format converter: random stream traffic against a predictor.
`timescale 1ns / 100ps

module tb_pixel_format_converter_unit;
  import pfc_pkg::*;

  // Significand of the single-precision value of 1/255; 2^32/255 shares it.
  localparam logic [23:0] RECIP_255_SIG = 24'h808081;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES = 12;

  typedef struct {
    logic [127:0] pixel;
    logic         bad;
  } pixel_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // in_ch0, in_ch1, in_ch2, in_ch3
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;      // out_ch0, out_ch1, out_ch2, out_ch3
  logic         out_tuser;      // bad_channels
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [2:0]   cfg_wdata = '0;

  // Shadow copy of the configuration registers.
  logic [1:0] src_kind_q = KIND_F32;
  logic [1:0] dst_kind_q = KIND_F32;
  logic [2:0] src_ch_q = 3'd4;
  logic [2:0] dst_ch_q = 3'd4;

  pixel_result_t pending_pixels[$];
  int mismatches = 0;
  int pixels_checked = 0;
  int pixels_sent = 0;
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  int stall_left = 0;

  pixel_format_converter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb_pixel_format_converter_unit NOT OK");
    $finish;
  end

  // Round a non-negative integer to 24 significant bits, nearest even: value = m * 2^sh.
  function automatic void round_sig24(input logic [63:0] x, output logic [23:0] m,
                                      output int sh);
    int p;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    p = 0;
    for (int i = 0; i < 64; i++) if (x[i]) p = i;
    if (p <= 23) begin
      mant = x << (23 - p);
      sh = p - 23;
    end else begin
      sh = p - 23;
      mant = x >> sh;
      rem = x & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
      if (mant[24]) begin
        mant = mant >> 1;
        sh = sh + 1;
      end
    end
    m = mant[23:0];
  endfunction

  // Truncate m * 2^k toward zero.
  function automatic logic [63:0] floor_scaled(input logic [23:0] m, input int k);
    if (k >= 0) return {40'd0, m} << k;
    if (k <= -64) return 64'd0;
    return {40'd0, m} >> (-k);
  endfunction

  function automatic logic [31:0] saturate(input logic [63:0] v, input logic [31:0] max);
    return (v > {32'd0, max}) ? max : v[31:0];
  endfunction

  function automatic logic [31:0] convert_channel(input logic [31:0] raw);
    logic [7:0]  b8;
    logic [7:0]  ex;
    logic [23:0] mm;
    logic [23:0] m;
    logic [23:0] m2;
    int          sh;
    int          sh2;
    int          e;
    b8 = raw[7:0];
    ex = raw[30:23];
    case (src_kind_q)
      KIND_F32: begin
        if (dst_kind_q == KIND_F32) return raw;
        if (dst_kind_q != KIND_U32 && dst_kind_q != KIND_U8) return 32'd0;
        // NaN, negatives and zero clamp to zero; one and above (infinity too) to one.
        if ((ex == 8'hFF && raw[22:0] != 0) || raw[31] || raw == 32'd0) return 32'd0;
        if (raw >= 32'h3F80_0000)
          return (dst_kind_q == KIND_U32) ? 32'hFFFF_FFFF : 32'h0000_00FF;
        mm = (ex == 8'd0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};
        e = (ex == 8'd0) ? -149 : int'(ex) - 150;
        if (dst_kind_q == KIND_U32) return saturate(floor_scaled(mm, e + 32), 32'hFFFF_FFFF);
        round_sig24({40'd0, mm} * 64'd255, m, sh);
        return saturate(floor_scaled(m, sh + e), 32'hFF);
      end
      KIND_U32: begin
        case (dst_kind_q)
          KIND_F32: begin
            if (raw == 32'd0) return 32'd0;
            round_sig24({32'd0, raw}, m, sh);
            return {1'b0, 8'(sh + 23 + 127 - 32), m[22:0]};
          end
          KIND_U32: return raw;
          KIND_U8: begin
            round_sig24({32'd0, raw}, m, sh);
            round_sig24({40'd0, m} * 64'd255, m2, sh2);
            return saturate(floor_scaled(m2, sh + sh2 - 32), 32'hFF);
          end
          default: return 32'd0;
        endcase
      end
      KIND_U8: begin
        case (dst_kind_q)
          KIND_F32: begin
            if (b8 == 8'd0) return 32'd0;
            round_sig24({56'd0, b8} * {40'd0, RECIP_255_SIG}, m, sh);
            return {1'b0, 8'(sh - 31 + 23 + 127), m[22:0]};
          end
          KIND_U32: begin
            round_sig24({56'd0, b8} * {40'd0, RECIP_255_SIG}, m, sh);
            return saturate(floor_scaled(m, sh + 1), 32'hFFFF_FFFF);
          end
          KIND_U8: return {24'd0, b8};
          default: return 32'd0;
        endcase
      end
      default: return 32'd0;
    endcase
  endfunction

  function automatic pixel_result_t convert_pixel(input logic [127:0] pixel);
    pixel_result_t r;
    int sc;
    int dc;
    sc = (src_ch_q > 3'd4) ? 4 : int'(src_ch_q);
    dc = (dst_ch_q > 3'd4) ? 4 : int'(dst_ch_q);
    r.pixel = '0;
    for (int i = 0; i < 4; i++)
      if (i < dc) r.pixel[32*i +: 32] = convert_channel(pixel[32*i +: 32]);
    r.bad = (dc > sc);
    return r;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Accepted results are compared against the oldest prediction.
  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_px = pending_pixels.pop_front();
        pixels_checked++;
        for (int i = 0; i < 4; i++)
          if (out_tdata[32*i +: 32] !== exp_px.pixel[32*i +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("out_ch%0d: expected %h, got %h", i, exp_px.pixel[32*i +: 32],
                       out_tdata[32*i +: 32]);
          end
        if (out_tuser !== exp_px.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bad_channels: expected %b, got %b", exp_px.bad, out_tuser);
        end
      end
    end
  end

  // Receiver back-pressure: mostly short holds, now and then a long one.
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!receiver_stalls) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_tready <= 1'b1;
      end else begin
        stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        out_tready <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic [127:0] pixel);
    int gap;
    gap = sender_gaps ? gap_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pixel;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pixels.push_back(convert_pixel(pixel));
    pixels_sent++;
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // The write enable stays high across consecutive writes; the caller drops it.
  task automatic write_reg(input logic [1:0] addr, input logic [2:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      REG_SRC_KIND: src_kind_q = value[1:0];
      REG_DST_KIND: dst_kind_q = value[1:0];
      REG_SRC_CH:   src_ch_q = value;
      default:      dst_ch_q = value;
    endcase
  endtask

  task automatic set_format(input logic [2:0] sk, input logic [2:0] dk,
                            input logic [2:0] sc, input logic [2:0] dc);
    wait_all_results();
    write_reg(REG_SRC_KIND, sk);
    write_reg(REG_DST_KIND, dk);
    write_reg(REG_SRC_CH, sc);
    write_reg(REG_DST_CH, dc);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_channel();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1: return $urandom();
      2, 3: return {1'b0, 8'($urandom_range(90, 126)), 23'($urandom())};
      4: return {24'd0, 8'($urandom())};
      5: return {1'b1, 31'($urandom())};
      6: return {1'b0, 8'hFF, 23'($urandom_range(0, 3))};
      7: return {9'd0, 23'($urandom())};
      8: return 32'h3F80_0000 + $urandom_range(0, 3) - 2;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pixel({32'h7FC0_0001, 32'hFF80_0000, 32'h8000_0000, 32'h3F80_0000});
    send_pixel({32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7F7F_FFFF});
  endtask

  // Every kind pair, the unused code included, with extreme channel values.
  task automatic test_kind_pairs();
    logic [31:0] extremes[8];
    logic [127:0] px;
    extremes = '{32'h3F80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h7F80_0000, 32'h3F7F_FFFF, 32'h0000_00FF, 32'hBF80_0000};
    for (int p = 0; p < 16; p++) begin
      set_format(3'(p / 4), 3'(p % 4), 3'd4, 3'd4);
      for (int i = 0; i < 4; i++) px[32*i +: 32] = extremes[(p + i) % 8];
      send_pixel(px);
    end
  endtask

  // Channel counts at and beyond their range, with too many destination channels.
  task automatic test_channel_counts();
    logic [2:0] counts[6][2];
    counts = '{'{3'd1, 3'd4}, '{3'd0, 3'd0}, '{3'd7, 3'd5}, '{3'd3, 3'd2},
               '{3'd2, 3'd6}, '{3'd6, 3'd1}};
    for (int i = 0; i < 6; i++) begin
      set_format({1'b0, KIND_F32}, {1'b0, KIND_U8}, counts[i][0], counts[i][1]);
      send_pixel({32'h3F00_0000, 32'h3E80_0000, 32'h3F80_0000, 32'h3C00_0000});
    end
  endtask

  task automatic test_random_traffic();
    logic [127:0] px;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Kind writes use all three bits; only the low two select the kind.
      set_format($urandom_range(0, 7), $urandom_range(0, 7),
                 (ph % 3 == 0) ? 3'd4 : 3'($urandom_range(0, 7)),
                 (ph % 3 == 0) ? 3'd4 : 3'($urandom_range(0, 7)));
      sender_gaps = (ph % 4 != 1);
      receiver_stalls = (ph % 4 != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        for (int i = 0; i < 4; i++) px[32*i +: 32] = random_channel();
        send_pixel(px);
        if (n == ITEMS_PER_PHASE / 2 && ph % 2 == 0) wait_all_results();
      end
    end
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_kind_pairs();
    test_channel_counts();
    test_random_traffic();
    wait_all_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels and checked %0d results across all kind pairs,", pixels_sent,
             pixels_checked);
    $display("channel counts from 0 to 7, and random sender gaps and receiver stalls.");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb_pixel_format_converter_unit OK");
    end else begin
      $display("tb_pixel_format_converter_unit NOT OK");
    end
    $finish;
  end

endmodule
